### rtl/core/fsdg_pkg.sv
// ----------------------------------------------------------------------------
// fsdg_pkg
// Shared types, constants and arithmetic helpers for the gray error-diffusion
// dither: beat layouts, line buffer geometry and saturating error math.
// ----------------------------------------------------------------------------
package fsdg_pkg;

    // line buffer geometry
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int CNT_W     = $clog2(MAX_WIDTH + 1);

    // field widths
    localparam int PIX_W     = 8;
    localparam int LW_W      = 12;
    localparam int THR_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int ERR_W     = 10;
    localparam int WIDE_W    = 14;
    localparam int SUM_W     = 10;
    localparam int PROD_W    = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b1;

    // configuration reset values
    localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 12'd2048;
    localparam logic [THR_W-1:0] THRESHOLD_RST  = 8'd127;

    // gray = sum / 3 as multiply by reciprocal, exact for sums up to 765
    localparam logic [SUM_W-1:0] GRAY_MUL   = 10'd683;
    localparam int               GRAY_SHIFT = 11;

    // output levels
    localparam logic [PIX_W-1:0]         LEVEL_HI   = 8'd255;
    localparam logic [PIX_W-1:0]         LEVEL_LO   = 8'd0;
    localparam logic signed [WIDE_W-1:0] LEVEL_HI_W = 14'sd255;

    // error limits and divide-by-16 helpers
    localparam logic signed [WIDE_W-1:0] ERR_MAX_W = 14'sd511;
    localparam logic signed [WIDE_W-1:0] ERR_MIN_W = -14'sd512;
    localparam logic signed [WIDE_W-1:0] DIV_BIAS  = 14'sd15;
    localparam int                       DIV_SHIFT = 4;

    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic signed [ERR_W-1:0] err_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    // input beat
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_start;
    } pixel_in_t;

    // output beat
    typedef struct packed {
        logic [PIX_W-1:0] out_level;
        logic             line_end;
    } pixel_out_t;

    // pixel waiting for its line buffer word
    typedef struct packed {
        addr_t            col;
        logic             last;
        logic             frame_start;
        logic [PIX_W-1:0] gray;
    } tag_t;

    // one line buffer write
    typedef struct packed {
        logic  en;
        addr_t addr;
        err_t  data;
    } ram_wr_t;

    // write port usage of the diffusion stage
    typedef struct packed {
        logic primary_en;
        logic pend_valid;
    } diff_status_t;

    // sign-extend an error term
    function automatic wide_t widen(input err_t e);
        return {{(WIDE_W-ERR_W){e[ERR_W-1]}}, e};
    endfunction

    // saturate to the error range
    function automatic err_t sat_err(input wide_t v);
        if (v > ERR_MAX_W)
            return ERR_W'(ERR_MAX_W);
        if (v < ERR_MIN_W)
            return ERR_W'(ERR_MIN_W);
        return ERR_W'(v);
    endfunction

    // divide by 16, truncating toward zero
    function automatic wide_t div16(input wide_t v);
        wide_t biased;
        biased = v[WIDE_W-1] ? (v + DIV_BIAS) : v;
        return biased >>> DIV_SHIFT;
    endfunction

endpackage

### rtl/core/fsdg_ram.sv
// ----------------------------------------------------------------------------
// fsdg_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read. A read and write to the same entry return the old data.
// ----------------------------------------------------------------------------
module fsdg_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/fsdg_front.sv
// ----------------------------------------------------------------------------
// fsdg_front
// Entry stage: tracks the column, issues the line buffer read address and
// registers the gray level and row position of each accepted pixel.
// ----------------------------------------------------------------------------
module fsdg_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  fsdg_pkg::pixel_in_t      pixel,
    input  logic [fsdg_pkg::LW_W-1:0] line_width,
    output fsdg_pkg::addr_t          rd_addr,
    output fsdg_pkg::tag_t           tag
);
    import fsdg_pkg::*;

    addr_t               col_reg;
    addr_t               col_next;
    cnt_t                w_eff;
    addr_t               last_col;
    addr_t               col;
    logic                last;
    logic [SUM_W-1:0]    sum;
    logic [PROD_W-1:0]   prod;
    logic [PIX_W-1:0]    gray;

    // effective row width, clamped to 1..MAX_WIDTH
    always_comb
    begin
        if (line_width == '0)
            w_eff = CNT_W'(1);
        else if (int'(line_width) > MAX_WIDTH)
            w_eff = CNT_W'(MAX_WIDTH);
        else
            w_eff = CNT_W'(line_width);
        last_col = ADDR_W'(w_eff - CNT_W'(1));
    end

    // column of this pixel and next column
    always_comb
    begin
        if (pixel.frame_start)
            col = '0;
        else if (col_reg >= last_col)
            col = last_col;
        else
            col = col_reg;
        last     = (col == last_col);
        col_next = last ? '0 : (col + ADDR_W'(1));
    end

    assign rd_addr = col;

    // gray level
    assign sum  = SUM_W'(pixel.red) + SUM_W'(pixel.green) + SUM_W'(pixel.blue);
    assign prod = PROD_W'(sum) * PROD_W'(GRAY_MUL);
    assign gray = PIX_W'(prod >> GRAY_SHIFT);

    // column counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
        end
    end

    // pixel tag for the diffusion stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag.col         <= col;
            tag.last        <= last;
            tag.frame_start <= pixel.frame_start;
            tag.gray        <= gray;
        end
    end

endmodule

### rtl/core/fsdg_diffuse.sv
// ----------------------------------------------------------------------------
// fsdg_diffuse
// Diffusion stage: adds the incoming error, thresholds, splits the error
// into the four weighted terms and produces the line buffer write-back.
// The end-of-row write is registered and issued in the next free write slot.
// ----------------------------------------------------------------------------
module fsdg_diffuse (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  fsdg_pkg::tag_t             tag,
    input  fsdg_pkg::err_t             mem_word,
    input  logic [fsdg_pkg::THR_W-1:0] threshold,
    output fsdg_pkg::ram_wr_t          ram_wr,
    output fsdg_pkg::pixel_out_t       beat,
    output fsdg_pkg::diff_status_t     status
);
    import fsdg_pkg::*;

    // error state
    err_t    right_reg;
    err_t    pending_reg;
    err_t    partial_reg;
    cnt_t    fill_reg;
    cnt_t    fill_next;
    ram_wr_t pend_reg;

    err_t    right_in;
    err_t    pending_in;
    err_t    partial_in;
    err_t    below_in;
    logic    mem_valid;
    wide_t   sum;
    err_t    lvl;
    logic    hi;
    wide_t   e;
    wide_t   t1;
    wide_t   t3;
    wide_t   t5;
    wide_t   t7;
    err_t    wr_left;
    err_t    new_partial;
    err_t    new_pending;
    err_t    new_right;
    ram_wr_t primary;
    logic    defer_en;
    cnt_t    col_w;

    assign col_w = CNT_W'(tag.col);

    // incoming error, cleared at frame start; unwritten entries read as zero
    always_comb
    begin
        mem_valid  = (col_w < fill_reg) && !tag.frame_start;
        below_in   = mem_valid ? mem_word : '0;
        right_in   = tag.frame_start ? '0 : right_reg;
        pending_in = tag.frame_start ? '0 : pending_reg;
        partial_in = tag.frame_start ? '0 : partial_reg;
    end

    // threshold and error split
    always_comb
    begin
        sum = wide_t'({{(WIDE_W-PIX_W){1'b0}}, tag.gray}) + widen(right_in) + widen(below_in);
        lvl = sat_err(sum);
        hi  = lvl > $signed({{(ERR_W-THR_W){1'b0}}, threshold});
        e   = widen(lvl) - (hi ? LEVEL_HI_W : '0);
        t1  = div16(e);
        t3  = div16(e + (e <<< 1));
        t5  = div16(e + (e <<< 2));
        t7  = div16((e <<< 3) - e);
        wr_left     = sat_err(widen(partial_in) + t3);
        new_partial = sat_err(widen(pending_in) + t5);
        new_pending = sat_err(t1);
        new_right   = sat_err(t7);
    end

    // write-back: left neighbor now, own column at row end
    always_comb
    begin
        primary  = '0;
        defer_en = 1'b0;
        if (tag.col != '0)
        begin
            primary.en   = fire;
            primary.addr = tag.col - ADDR_W'(1);
            primary.data = wr_left;
            defer_en     = fire && tag.last;
        end
        else if (tag.last)
        begin
            primary.en   = fire;
            primary.addr = tag.col;
            primary.data = new_partial;
        end
    end

    // physical write port: primary write wins, else the deferred one
    always_comb
    begin
        if (primary.en)
            ram_wr = primary;
        else
            ram_wr = pend_reg;
    end

    // highest written column plus one since frame start
    always_comb
    begin
        fill_next = tag.frame_start ? '0 : fill_reg;
        if (tag.col != '0 && fill_next < col_w)
            fill_next = col_w;
        if (tag.last && fill_next < (col_w + CNT_W'(1)))
            fill_next = col_w + CNT_W'(1);
    end

    // error registers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_reg   <= '0;
            pending_reg <= '0;
            partial_reg <= '0;
            fill_reg    <= '0;
        end
        else if (fire)
        begin
            fill_reg <= fill_next;
            if (tag.last)
            begin
                right_reg   <= '0;
                pending_reg <= '0;
                partial_reg <= '0;
            end
            else
            begin
                right_reg   <= new_right;
                pending_reg <= new_pending;
                partial_reg <= new_partial;
            end
        end
    end

    // deferred end-of-row write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (defer_en)
        begin
            pend_reg.en   <= 1'b1;
            pend_reg.addr <= tag.col;
            pend_reg.data <= new_partial;
        end
        else if (!primary.en)
        begin
            pend_reg.en <= 1'b0;
        end
    end

    // result beat
    assign beat.out_level = hi ? LEVEL_HI : LEVEL_LO;
    assign beat.line_end  = tag.last;

    assign status.primary_en = primary.en;
    assign status.pend_valid = pend_reg.en;

endmodule

### rtl/core/floyd_steinberg_dither_gray.sv
// ----------------------------------------------------------------------------
// floyd_steinberg_dither_gray
// Path: accepted pixel -> entry-stage tag register -> output register.
// Throughput: 1 pixel per cycle unless result_ready stalls, set by the error
//   loop and one line buffer write per cycle; row-end write uses next row's slot.
// Reset: line_width 2048, threshold 127, column 0, line buffer reads as zero
//   through a fill count (no clearing pass); frame_start restarts it.
// ----------------------------------------------------------------------------
// RGB to gray Floyd-Steinberg error diffusion, one pixel per clock unless the output
// stalls. The next row's error lives in a synchronous line buffer read at accept and
// written back by the diffusion stage, with same-cycle write forwarding.
// ----------------------------------------------------------------------------
module floyd_steinberg_dither_gray (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [fsdg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsdg_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           pixel_valid,
    output logic                           pixel_ready,
    input  fsdg_pkg::pixel_in_t            pixel,
    output logic                           result_valid,
    input  logic                           result_ready,
    output fsdg_pkg::pixel_out_t           result
);
    import fsdg_pkg::*;

    logic [LW_W-1:0]  line_width_reg;
    logic [THR_W-1:0] threshold_reg;
    logic             s1_valid_reg;
    logic             out_valid_reg;
    pixel_out_t       out_data_reg;
    logic             fwd_hit_reg;
    err_t             fwd_data_reg;

    logic             accept;
    logic             fire;
    addr_t            rd_addr;
    tag_t             tag;
    err_t             rdata;
    err_t             mem_word;
    ram_wr_t          ram_wr;
    pixel_out_t       beat;
    diff_status_t     status;

    // handshake
    assign fire        = s1_valid_reg && (!out_valid_reg || result_ready);
    assign pixel_ready = !s1_valid_reg || fire;
    assign accept      = pixel_valid && pixel_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RST;
            threshold_reg  <= THRESHOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_LINE_WIDTH: line_width_reg <= cfg_data;
                CFG_THRESHOLD:  threshold_reg  <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // entry stage
    fsdg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .pixel      (pixel),
        .line_width (line_width_reg),
        .rd_addr    (rd_addr),
        .tag        (tag)
    );

    // next-row error line buffer
    fsdg_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (ERR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_wr.en),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // forward a write that lands on the entry being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (accept)
        begin
            fwd_hit_reg <= ram_wr.en && (ram_wr.addr == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg <= ram_wr.data;
        end
    end

    assign mem_word = fwd_hit_reg ? fwd_data_reg : rdata;

    // diffusion stage
    fsdg_diffuse u_diffuse (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .tag       (tag),
        .mem_word  (mem_word),
        .threshold (threshold_reg),
        .ram_wr    (ram_wr),
        .beat      (beat),
        .status    (status)
    );

    // stage valid and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (fire)
                s1_valid_reg <= 1'b0;

            if (fire)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= beat;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    // the deferred row-end write never meets a primary write
    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(status.primary_en && status.pend_valid))
        else $error("line buffer write port used twice in one cycle");

    // nothing overwrites the entry a waiting pixel has already read
    a_no_late_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !fire) |-> !(ram_wr.en && ram_wr.addr == tag.col))
        else $error("line buffer entry written after its read was issued");

    // a row-end pixel past column 0 leaves a deferred write for the next cycle
    a_row_end_defer: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && tag.last && tag.col != '0) |=> status.pend_valid)
        else $error("row-end write-back lost");

    // results are pure black or white
    a_level_binary: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.out_level == LEVEL_HI || result.out_level == LEVEL_LO))
        else $error("result level is not black or white");

endmodule

### dv/dither_checker.sv
// ----------------------------------------------------------------------------
// dither_checker
// Watches the pixel, result and register ports of the gray dither block,
// runs its own error-diffusion model on every accepted pixel beat and
// compares each result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dither_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [fsdg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fsdg_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           pixel_valid,
    input  logic                           pixel_ready,
    input  fsdg_pkg::pixel_in_t            pixel,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  fsdg_pkg::pixel_out_t           result,
    output int                             pending_cnt,
    output int                             mismatch_cnt
);
    import fsdg_pkg::*;

    // model state: next-row error per column and the in-row carries
    err_t             below_row_err [MAX_WIDTH];
    err_t             carry_right;
    err_t             carry_below_right;
    err_t             below_open;
    int               next_col;
    logic [LW_W-1:0]  row_len;
    logic [THR_W-1:0] cut_level;

    // predicted result beats, oldest first
    pixel_out_t       level_q [$];
    int               fail_cnt;

    function automatic int clamp_err(input int v);
        if (v > int'(ERR_MAX_W))
            return int'(ERR_MAX_W);
        if (v < int'(ERR_MIN_W))
            return int'(ERR_MIN_W);
        return v;
    endfunction

    // wipe the line buffer and the carries
    task automatic clear_rows();
        for (int i = 0; i < MAX_WIDTH; i++)
            below_row_err[i] = '0;
        carry_right       = '0;
        carry_below_right = '0;
        below_open        = '0;
        next_col          = 0;
    endtask

    // threshold one pixel and spread its error to the neighbors
    task automatic dither_pixel(input pixel_in_t p, output pixel_out_t o);
        int   w;
        int   col;
        int   gray;
        int   lvl;
        int   err;
        logic last;
        if (p.frame_start)
            clear_rows();
        w = int'(row_len);
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        col = next_col;
        if (col >= w)
            col = w - 1;
        last = (col == w - 1);

        gray = (int'(p.red) + int'(p.green) + int'(p.blue)) / 3;
        lvl  = clamp_err(gray + int'(carry_right) + int'(below_row_err[col]));
        o.out_level = (lvl > int'(cut_level)) ? LEVEL_HI : LEVEL_LO;
        err = lvl - int'(o.out_level);

        // below-left closes, below and below-right open up
        if (col > 0)
            below_row_err[col-1] = err_t'(clamp_err(int'(below_open) + (3 * err) / 16));
        below_open        = err_t'(clamp_err(int'(carry_below_right) + (5 * err) / 16));
        carry_below_right = err_t'(clamp_err(err / 16));
        carry_right       = err_t'(clamp_err((7 * err) / 16));

        // row end flushes the open column and drops what falls off the edge
        if (last)
        begin
            below_row_err[col] = below_open;
            below_open         = '0;
            carry_below_right  = '0;
            carry_right        = '0;
            next_col           = 0;
        end
        else
        begin
            next_col = col + 1;
        end
        o.line_end = last;
    endtask

    // port monitor: register writes, result compare, pixel prediction
    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_out_t want;
        if (!rst_n)
        begin
            clear_rows();
            row_len   = LINE_WIDTH_RST;
            cut_level = THRESHOLD_RST;
            level_q.delete();
            fail_cnt  = 0;
            pending_cnt  <= 0;
            mismatch_cnt <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_LINE_WIDTH)
                    row_len = cfg_data[LW_W-1:0];
                else if (cfg_index == CFG_THRESHOLD)
                    cut_level = cfg_data[THR_W-1:0];
            end

            if (result_valid && result_ready)
            begin
                if (level_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result beat: level %0d line_end %0b",
                                 result.out_level, result.line_end);
                end
                else
                begin
                    want = level_q.pop_front();
                    if (result.out_level !== want.out_level ||
                        result.line_end !== want.line_end)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display({"result mismatch: expected level %0d line_end %0b,",
                                      " got level %0d line_end %0b"},
                                     want.out_level, want.line_end,
                                     result.out_level, result.line_end);
                    end
                end
            end

            if (pixel_valid && pixel_ready)
            begin
                dither_pixel(pixel, want);
                level_q.push_back(want);
            end

            pending_cnt  <= level_q.size();
            mismatch_cnt <= fail_cnt;
        end
    end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the gray dither block with directed corner pixels and random frames
// over many widths and thresholds, with random gaps and output stalls; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import fsdg_pkg::*;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_LINE_WIDTH;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 pixel_valid  = 1'b0;
    logic                 pixel_ready;
    pixel_in_t            pixel        = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    pixel_out_t           result;
    int                   pending_cnt;
    int                   mismatch_cnt;

    bit                   tx_quiet     = 1'b0;
    bit                   rx_quiet     = 1'b0;
    int unsigned          rx_hold      = 0;
    int                   random_sent  = 0;

    always #5 clk = ~clk;

    floyd_steinberg_dither_gray u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    dither_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .pending_cnt  (pending_cnt),
        .mismatch_cnt (mismatch_cnt)
    );

    // output stall: a fresh hold-off after every accepted result beat
    always @(posedge clk or negedge rst_n)
    begin : rx_pace
        int unsigned draw;
        if (!rst_n)
        begin
            rx_hold      <= 0;
            result_ready <= 1'b0;
        end
        else if (result_valid && result_ready)
        begin
            draw = rx_quiet ? 0 : $urandom_range(0, 16);
            rx_hold      <= draw;
            result_ready <= (draw == 0);
        end
        else if (rx_hold != 0)
        begin
            rx_hold      <= rx_hold - 1;
            result_ready <= (rx_hold == 1);
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    function automatic pixel_in_t mk_pixel(input int r, input int g, input int b,
                                           input bit fs);
        pixel_in_t p;
        p.red         = PIX_W'(r);
        p.green       = PIX_W'(g);
        p.blue        = PIX_W'(b);
        p.frame_start = fs;
        return p;
    endfunction

    // random pixel: full noise, a flat gray patch, or saturated colors
    function automatic pixel_in_t draw_pixel(input int style, input int base,
                                             input bit fs);
        pixel_in_t p;
        int        v;
        case (style)
            0:
            begin
                p.red   = PIX_W'($urandom);
                p.green = PIX_W'($urandom);
                p.blue  = PIX_W'($urandom);
            end
            1:
            begin
                v = base + $urandom_range(0, 16) - 8;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                p.red   = PIX_W'(v);
                p.green = PIX_W'(v);
                p.blue  = PIX_W'(v);
            end
            default:
            begin
                p.red   = $urandom_range(0, 1) ? LEVEL_HI : LEVEL_LO;
                p.green = $urandom_range(0, 1) ? LEVEL_HI : LEVEL_LO;
                p.blue  = $urandom_range(0, 1) ? LEVEL_HI : LEVEL_LO;
            end
        endcase
        p.frame_start = fs;
        return p;
    endfunction

    // one pixel beat, after a random gap unless the sender runs flat out
    task automatic send_pixel(input pixel_in_t p);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        do
            @(posedge clk);
        while (!pixel_ready);
    endtask

    // wait until every predicted beat has come back, then let the pipe empty
    task automatic settle();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending_cnt != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // both registers, only while the block is idle
    task automatic write_cfg(input int width, input int thr);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LINE_WIDTH;
        cfg_data  <= CFG_W'(width);
        @(posedge clk);
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= CFG_W'(thr);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        int w;
        int w_eff;
        int thr;
        int n;
        int style;
        int base;
        int pick;
        bit new_frame;
        bit fs;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: black, white, primaries, a level at the threshold
        send_pixel(mk_pixel(0, 0, 0, 1'b1));
        send_pixel(mk_pixel(255, 255, 255, 1'b0));
        send_pixel(mk_pixel(255, 0, 0, 1'b0));
        send_pixel(mk_pixel(0, 255, 0, 1'b0));
        send_pixel(mk_pixel(0, 0, 255, 1'b0));
        send_pixel(mk_pixel(128, 128, 127, 1'b0));

        // one-pixel rows, lowest threshold
        write_cfg(1, 0);
        send_pixel(mk_pixel(0, 0, 0, 1'b1));
        send_pixel(mk_pixel(1, 0, 0, 1'b0));
        send_pixel(mk_pixel(255, 255, 255, 1'b0));

        // two short rows, highest threshold
        write_cfg(3, 255);
        send_pixel(mk_pixel(255, 255, 255, 1'b1));
        send_pixel(mk_pixel(255, 255, 255, 1'b0));
        send_pixel(mk_pixel(254, 255, 255, 1'b0));
        send_pixel(mk_pixel(0, 0, 0, 1'b0));
        send_pixel(mk_pixel(255, 255, 255, 1'b0));
        send_pixel(mk_pixel(255, 255, 255, 1'b0));

        // zero width acts as one
        write_cfg(0, 127);
        send_pixel(mk_pixel(200, 100, 50, 1'b0));
        send_pixel(mk_pixel(10, 20, 30, 1'b0));

        // width beyond the line buffer acts as the buffer size
        write_cfg(4095, 127);
        send_pixel(mk_pixel(90, 90, 90, 1'b1));
        send_pixel(mk_pixel(170, 170, 170, 1'b0));
        send_pixel(mk_pixel(90, 90, 90, 1'b0));

        // width shrunk below the current column ends the row at once
        write_cfg(2, 127);
        send_pixel(mk_pixel(60, 60, 60, 1'b0));

        // frame start in the middle of a row
        write_cfg(5, 127);
        send_pixel(mk_pixel(255, 255, 255, 1'b0));
        send_pixel(mk_pixel(100, 100, 100, 1'b1));
        send_pixel(mk_pixel(100, 100, 100, 1'b0));

        // random frames: mostly small widths, a few at or past the buffer size
        while (random_sent < 1550)
        begin
            pick = $urandom_range(0, 39);
            if (pick < 28)
                w = $urandom_range(1, 16);
            else if (pick < 36)
                w = $urandom_range(17, 80);
            else if (pick == 36)
                w = $urandom_range(0, 1) ? MAX_WIDTH : 4095;
            else if (pick == 37)
                w = 0;
            else if (pick == 38)
                w = $urandom_range(MAX_WIDTH + 1, 4095);
            else
                w = $urandom_range(1, 2);

            case ($urandom_range(0, 4))
                0:       thr = 0;
                1:       thr = 255;
                2:       thr = 127;
                default: thr = $urandom_range(0, 255);
            endcase

            w_eff = (w < 1) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
            n = $urandom_range(2, 6) * w_eff;
            if (n > 250)
                n = 250;
            new_frame = ($urandom_range(0, 3) != 0);
            style     = $urandom_range(0, 2);
            base      = $urandom_range(0, 255);

            write_cfg(w, thr);
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet <= ($urandom_range(0, 4) == 0);

            for (int i = 0; i < n; i++)
            begin
                fs = (i == 0 && new_frame) || ($urandom_range(0, 63) == 0);
                send_pixel(draw_pixel(style, base, fs));
                random_sent++;
            end
        end

        settle();
        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // hang guard
    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
